// File: rtl/rqs_pkg.sv
// package: record layout, key codes and key selection for the record sorter
`timescale 1ns / 1ps

package rqs_pkg;

    localparam int unsigned MaxItemsDefault = 64;

    // field widths
    localparam int unsigned TagW   = 16;
    localparam int unsigned RateW  = 7;
    localparam int unsigned YearW  = 12;
    localparam int unsigned AudW   = 24;
    localparam int unsigned RecW   = TagW + RateW + YearW + AudW;
    localparam int unsigned KeyW   = AudW;
    localparam int unsigned DataW  = 64;

    // bit positions of the fields inside a stored record
    localparam int unsigned RateLsb = TagW;
    localparam int unsigned YearLsb = TagW + RateW;
    localparam int unsigned AudLsb  = TagW + RateW + YearW;

    // sort key codes
    localparam logic [1:0] KEY_RATING   = 2'd0;
    localparam logic [1:0] KEY_YEAR     = 2'd1;
    localparam logic [1:0] KEY_AUDIENCE = 2'd2;

    typedef logic [RecW-1:0] rec_t;

    // range stack controls
    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctl_t;

    // key of one record, zero extended; unused code compares by rating
    function automatic logic [KeyW-1:0] key_of(input rec_t rec, input logic [1:0] sel);
        logic [KeyW-1:0] k;
        k = '0;
        case (sel)
            KEY_YEAR:     k = {{(KeyW-YearW){1'b0}}, rec[YearLsb +: YearW]};
            KEY_AUDIENCE: k = rec[AudLsb +: AudW];
            default:      k = {{(KeyW-RateW){1'b0}}, rec[RateLsb +: RateW]};
        endcase
        return k;
    endfunction

endpackage

// File: rtl/rqs_stack.sv
// range stack: memory of pending sort ranges with a depth counter
`timescale 1ns / 1ps

module rqs_stack #(
    parameter int unsigned MAX_ITEMS = rqs_pkg::MaxItemsDefault
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rqs_pkg::stack_ctl_t            ctl,
    input  logic [$clog2(MAX_ITEMS)-1:0]   push_lo,
    input  logic [$clog2(MAX_ITEMS)-1:0]   push_hi,
    output logic [$clog2(MAX_ITEMS)-1:0]   top_lo,
    output logic [$clog2(MAX_ITEMS)-1:0]   top_hi,
    output logic                           empty
);

    localparam int unsigned IW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = IW + 1;

    logic [2*IW-1:0] stk_mem [MAX_ITEMS];
    logic [2*IW-1:0] top_reg;
    logic [CW-1:0]   depth_reg;
    logic [CW-1:0]   depth_next;
    logic [CW-1:0]   dm1;
    logic            do_push;

    assign dm1     = depth_reg - CW'(1);
    assign do_push = ctl.push && (depth_reg < CW'(MAX_ITEMS));
    assign empty   = (depth_reg == '0);
    assign top_lo  = top_reg[2*IW-1:IW];
    assign top_hi  = top_reg[IW-1:0];

    // depth update
    always_comb
    begin
        depth_next = depth_reg;
        if (ctl.pop && !empty)
        begin
            depth_next = dm1;
        end
        else if (do_push)
        begin
            depth_next = depth_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    // stack memory, registered read of the top entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stk_mem[depth_reg[IW-1:0]] <= {push_lo, push_hi};
        end
        top_reg <= stk_mem[dm1[IW-1:0]];
    end

endmodule

// File: rtl/record_quicksort_by_key_top.sv
// top level: record loader, lomuto quicksort over a record memory, sorted output
//
// channel   | handshake              | payload
// s_*       | s_tvalid / s_tready    | s_tdata records, s_tlast ends the data set
// m_*       | m_tvalid / m_tready    | m_tdata sorted records, m_tlast, m_tuser overflow
// cfg_*     | cfg_valid / cfg_ready  | cfg_data sort key
//
// loading takes one record per cycle; the sort then runs on the record memory
// (one write, one read port): each element is compared with the pivot, a swap
// passes S_SWPR and S_SWPW, each range passes pop, pivot read, final swap and push;
// output holds each record until taken. no record is taken during sort or output.
// reset (rst_n, asynchronous) empties the store, the stack and the overflow mark.
`timescale 1ns / 1ps

module record_quicksort_by_key_top #(
    parameter int unsigned MAX_ITEMS = rqs_pkg::MaxItemsDefault
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // title_tag, rating_tenths, release_year, audience from bit 0 up
    input  logic [rqs_pkg::DataW-1:0] s_tdata,
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // out_tag, out_rating, out_year, out_audience from bit 0 up
    output logic [rqs_pkg::DataW-1:0] m_tdata,
    output logic                      m_tlast,
    // overflowed
    output logic                      m_tuser,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_data
);

    localparam int unsigned IW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = IW + 1;

    typedef enum logic [12:0] {
        S_LOAD  = 13'b0000000000001,
        S_POP   = 13'b0000000000010,
        S_POPW  = 13'b0000000000100,
        S_PIVW  = 13'b0000000001000,
        S_SCAN  = 13'b0000000010000,
        S_SWPR  = 13'b0000000100000,
        S_SWPW  = 13'b0000001000000,
        S_FINR  = 13'b0000010000000,
        S_FINW  = 13'b0000100000000,
        S_PUSH1 = 13'b0001000000000,
        S_PUSH2 = 13'b0010000000000,
        S_OUTW  = 13'b0100000000000,
        S_OUTH  = 13'b1000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [1:0]          key_reg;
    logic [IW-1:0]       lo_reg, lo_next;
    logic [IW-1:0]       hi_reg, hi_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [IW-1:0]       p_reg, p_next;
    logic [IW-1:0]       j_reg, j_next;
    rqs_pkg::rec_t       piv_reg, piv_next;
    rqs_pkg::rec_t       cur_reg, cur_next;
    rqs_pkg::rec_t       out_reg, out_next;
    logic                out_last_reg, out_last_next;
    logic                out_valid_reg, out_valid_next;

    // record memory ports
    rqs_pkg::rec_t       rec_mem [MAX_ITEMS];
    logic                rec_we;
    logic [IW-1:0]       rec_wa;
    rqs_pkg::rec_t       rec_wd;
    logic [IW-1:0]       rec_ra;
    rqs_pkg::rec_t       rd_q;

    // stack ports
    rqs_pkg::stack_ctl_t stk_ctl;
    logic [IW-1:0]       stk_lo, stk_hi;
    logic [IW-1:0]       top_lo, top_hi;
    logic                stk_empty;

    logic                in_acc;
    logic                out_acc;
    logic                less;
    logic [CW-1:0]       p_w, lo_w, hi_w, i_w;

    assign s_tready  = (state_reg == S_LOAD);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = out_valid_reg && m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(rqs_pkg::DataW-rqs_pkg::RecW){1'b0}}, out_reg};
    assign m_tlast   = out_last_reg;
    assign m_tuser   = ovf_reg;

    assign p_w  = {1'b0, p_reg};
    assign lo_w = {1'b0, lo_reg};
    assign hi_w = {1'b0, hi_reg};
    assign i_w  = {1'b0, i_reg};
    assign less = rqs_pkg::key_of(rd_q, key_reg) < rqs_pkg::key_of(piv_reg, key_reg);

    rqs_stack #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (stk_ctl),
        .push_lo (stk_lo),
        .push_hi (stk_hi),
        .top_lo  (top_lo),
        .top_hi  (top_hi),
        .empty   (stk_empty)
    );

    // record memory with write-to-read forwarding
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_wa] <= rec_wd;
        end
        rd_q <= (rec_we && (rec_wa == rec_ra)) ? rec_wd : rec_mem[rec_ra];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        p_next         = p_reg;
        j_next         = j_reg;
        piv_next       = piv_reg;
        cur_next       = cur_reg;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        rec_we         = 1'b0;
        rec_wa         = '0;
        rec_wd         = '0;
        rec_ra         = '0;
        stk_ctl        = '0;
        stk_lo         = '0;
        stk_hi         = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg < CW'(MAX_ITEMS))
                    begin
                        rec_we     = 1'b1;
                        rec_wa     = count_reg[IW-1:0];
                        rec_wd     = s_tdata[rqs_pkg::RecW-1:0];
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        j_next = '0;
                        if (count_next < CW'(2))
                        begin
                            rec_ra     = '0;
                            state_next = S_OUTW;
                        end
                        else
                        begin
                            stk_ctl.push = 1'b1;
                            stk_lo       = '0;
                            stk_hi       = IW'(count_next - CW'(1));
                            state_next   = S_POP;
                        end
                    end
                end
            end
            S_POP:
            begin
                if (stk_empty)
                begin
                    j_next     = '0;
                    rec_ra     = '0;
                    state_next = S_OUTW;
                end
                else
                begin
                    stk_ctl.pop = 1'b1;
                    state_next  = S_POPW;
                end
            end
            S_POPW:
            begin
                lo_next    = top_lo;
                hi_next    = top_hi;
                rec_ra     = top_hi;
                state_next = S_PIVW;
            end
            S_PIVW:
            begin
                piv_next   = rd_q;
                i_next     = lo_reg;
                p_next     = lo_reg;
                rec_ra     = lo_reg;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cur_next = rd_q;
                if (less && (i_reg != p_reg))
                begin
                    rec_ra     = p_reg;
                    state_next = S_SWPR;
                end
                else
                begin
                    if (less)
                    begin
                        p_next = p_reg + IW'(1);
                    end
                    i_next = i_reg + IW'(1);
                    if (i_w + CW'(1) == hi_w)
                    begin
                        rec_ra     = p_next;
                        state_next = S_FINR;
                    end
                    else
                    begin
                        rec_ra = i_reg + IW'(1);
                    end
                end
            end
            S_SWPR:
            begin
                rec_we     = 1'b1;
                rec_wa     = p_reg;
                rec_wd     = cur_reg;
                cur_next   = rd_q;
                state_next = S_SWPW;
            end
            S_SWPW:
            begin
                rec_we = 1'b1;
                rec_wa = i_reg;
                rec_wd = cur_reg;
                p_next = p_reg + IW'(1);
                i_next = i_reg + IW'(1);
                if (i_w + CW'(1) == hi_w)
                begin
                    rec_ra     = p_reg + IW'(1);
                    state_next = S_FINR;
                end
                else
                begin
                    rec_ra     = i_reg + IW'(1);
                    state_next = S_SCAN;
                end
            end
            S_FINR:
            begin
                rec_we     = 1'b1;
                rec_wa     = hi_reg;
                rec_wd     = rd_q;
                state_next = S_FINW;
            end
            S_FINW:
            begin
                rec_we     = 1'b1;
                rec_wa     = p_reg;
                rec_wd     = piv_reg;
                state_next = S_PUSH1;
            end
            S_PUSH1:
            begin
                // left part below the pivot
                if (p_w > lo_w + CW'(1))
                begin
                    stk_ctl.push = 1'b1;
                    stk_lo       = lo_reg;
                    stk_hi       = p_reg - IW'(1);
                end
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                // right part above the pivot
                if (hi_w > p_w + CW'(1))
                begin
                    stk_ctl.push = 1'b1;
                    stk_lo       = p_reg + IW'(1);
                    stk_hi       = hi_reg;
                end
                state_next = S_POP;
            end
            S_OUTW:
            begin
                out_next       = rd_q;
                out_last_next  = ({1'b0, j_reg} + CW'(1) == count_reg);
                out_valid_next = 1'b1;
                state_next     = S_OUTH;
            end
            S_OUTH:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        j_next     = j_reg + IW'(1);
                        rec_ra     = j_reg + IW'(1);
                        state_next = S_OUTW;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            key_reg       <= rqs_pkg::KEY_RATING;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                key_reg <= cfg_data;
            end
        end
    end

    // payload and index registers
    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        i_reg        <= i_next;
        p_reg        <= p_next;
        j_reg        <= j_next;
        piv_reg      <= piv_next;
        cur_reg      <= cur_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

endmodule
